/* rtl/core/lzmc_pkg.sv */
package lzmc_pkg;

  // command codes
  localparam logic [1:0] CMD_LITERAL = 2'd0;
  localparam logic [1:0] CMD_MATCH   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // deflate match length limits
  localparam int         LEN_W     = 9;
  localparam logic [8:0] MIN_MATCH = 9'd3;
  localparam logic [8:0] MAX_MATCH = 9'd258;

  // repeat_count * match_length
  localparam int PROD_W = 25;

  localparam int               CAP_W          = 17;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 17'd65536;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic lit_write;
    logic read_issue;
    logic byte_cap;
    logic copy_start;
    logic copy_step;
    logic st_ok;
    logic st_bad;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       lit_ok;
    logic       read_ok;
    logic       match_ok;
    logic       match_empty;
    logic       copy_done;
  } dp_sts_t;

endpackage

/* rtl/core/lzmc_ram.sv */
module lzmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/lzmc_datapath.sv */
module lzmc_datapath
  import lzmc_pkg::*;
#(
  parameter int BUFFER_BYTES = 65536,
  parameter int MAX_DISTANCE = 32768
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_cmd_t         cmd,
  output dp_sts_t          sts,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_capacity,
  input  logic [1:0]       in_command,
  input  logic [7:0]       in_literal,
  input  logic [15:0]      in_distance,
  input  logic [8:0]       in_match_length,
  input  logic [15:0]      in_repeat_count,
  input  logic [15:0]      in_read_position,
  output logic             out_status,
  output logic [16:0]      out_fill_level,
  output logic [7:0]       out_read_byte
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FW = AW + 1;
  localparam int CW = (FW > CAP_W) ? FW : CAP_W;
  localparam int TW = ((CW > PROD_W) ? CW : PROD_W) + 1;

  logic [CAP_W-1:0]  cap_r;
  logic [FW-1:0]     fill_r;
  logic [1:0]        cmd_r;
  logic [7:0]        lit_r;
  logic [15:0]       dist_r;
  logic [LEN_W-1:0]  len_r;
  logic [15:0]       reps_r;
  logic [15:0]       rpos_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] rd_left_r;
  logic [AW-1:0]     src_r;
  logic              wr_pend_r;
  logic              byp_r;
  logic [7:0]        byp_data_r;
  logic              st_r;
  logic [7:0]        rbyte_r;
  logic              out_status_r;
  logic [16:0]       out_fill_r;
  logic [7:0]        out_byte_r;

  logic [CW-1:0]     limit;
  logic              dist_ok;
  logic              len_ok;
  logic              room_ok;
  logic              rd_go;
  logic              byp_nxt;
  logic [7:0]        copy_data;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_q;

  assign limit = (CW'(cap_r) < CW'(BUFFER_BYTES)) ? CW'(cap_r) : CW'(BUFFER_BYTES);

  assign dist_ok = (dist_r != 16'd0) && (CW'(dist_r) <= CW'(fill_r)) &&
                   (CW'(dist_r) <= CW'(MAX_DISTANCE));
  assign len_ok  = (len_r >= MIN_MATCH) && (len_r <= MAX_MATCH);
  assign room_ok = (TW'(fill_r) + TW'(prod_r)) <= TW'(limit);

  assign sts.cmd         = cmd_r;
  assign sts.lit_ok      = CW'(fill_r) < limit;
  assign sts.read_ok     = CW'(rpos_r) < CW'(fill_r);
  assign sts.match_ok    = dist_ok && len_ok && room_ok;
  assign sts.match_empty = (prod_r == '0);
  assign sts.copy_done   = (rd_left_r == '0) && !wr_pend_r;

  // copy pipe: read source this cycle, write destination next cycle
  assign rd_go     = cmd.copy_step && (rd_left_r != '0);
  assign copy_data = byp_r ? byp_data_r : ram_q;

  assign ram_we    = cmd.lit_write || (cmd.copy_step && wr_pend_r);
  assign ram_waddr = fill_r[AW-1:0];
  assign ram_wdata = cmd.lit_write ? lit_r : copy_data;
  assign ram_re    = cmd.read_issue || rd_go;
  assign ram_raddr = cmd.read_issue ? AW'(rpos_r) : src_r;

  // distance one reads the byte being written in the same cycle
  assign byp_nxt = rd_go && wr_pend_r && (src_r == fill_r[AW-1:0]);

  lzmc_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAPACITY_RESET;
      fill_r    <= '0;
      rd_left_r <= '0;
      wr_pend_r <= 1'b0;
      byp_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
      if (ram_we) begin
        fill_r <= fill_r + FW'(1);
      end
      if (cmd.copy_start) begin
        rd_left_r <= prod_r;
        wr_pend_r <= 1'b0;
        byp_r     <= 1'b0;
      end else if (cmd.copy_step) begin
        if (rd_go) begin
          rd_left_r <= rd_left_r - PROD_W'(1);
        end
        wr_pend_r <= rd_go;
        byp_r     <= byp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      lit_r   <= in_literal;
      dist_r  <= in_distance;
      len_r   <= in_match_length;
      reps_r  <= in_repeat_count;
      rpos_r  <= in_read_position;
      rbyte_r <= 8'd0;
    end else if (cmd.byte_cap) begin
      rbyte_r <= ram_q;
    end
    prod_r <= PROD_W'(reps_r) * PROD_W'(len_r);
    if (cmd.copy_start) begin
      src_r <= fill_r[AW-1:0] - AW'(dist_r);
    end else if (rd_go) begin
      src_r <= src_r + AW'(1);
    end
    byp_data_r <= copy_data;
    if (cmd.st_ok) begin
      st_r <= 1'b0;
    end else if (cmd.st_bad) begin
      st_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_status_r <= st_r;
      out_fill_r   <= 17'(fill_r);
      out_byte_r   <= rbyte_r;
    end
  end

  assign out_status     = out_status_r;
  assign out_fill_level = out_fill_r;
  assign out_read_byte  = out_byte_r;

endmodule

/* rtl/core/lzmc_ctrl.sv */
module lzmc_ctrl
  import lzmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MCHK,
    S_COPY,
    S_RDWAIT,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_LITERAL: begin
            cmd.lit_write = sts.lit_ok;
            cmd.st_ok     = sts.lit_ok;
            cmd.st_bad    = !sts.lit_ok;
            state_nxt     = S_RESP;
          end
          CMD_MATCH: begin
            state_nxt = S_MCHK;
          end
          CMD_READ: begin
            if (sts.read_ok) begin
              cmd.read_issue = 1'b1;
              state_nxt      = S_RDWAIT;
            end else begin
              cmd.st_bad = 1'b1;
              state_nxt  = S_RESP;
            end
          end
          default: begin
            cmd.st_bad = 1'b1;
            state_nxt  = S_RESP;
          end
        endcase
      end
      S_MCHK: begin
        if (!sts.match_ok) begin
          cmd.st_bad = 1'b1;
          state_nxt  = S_RESP;
        end else if (sts.match_empty) begin
          cmd.st_ok = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.st_ok      = 1'b1;
          cmd.copy_start = 1'b1;
          state_nxt      = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RDWAIT: begin
        cmd.byte_cap = 1'b1;
        cmd.st_ok    = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/lz77_match_copy_engine.sv */
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall   | command, literal, distance, match_length,
//         |           |                       | repeat_count, read_position
// out_    | output    | out_valid / out_stall | status, fill_level, read_byte
// cfg_    | input     | cfg_valid / cfg_ready | capacity
//
// literal, unknown command, refused read: decode, then result; a read adds a wait state
// a match adds the check state, a copy the loop over repeat_count * match_length bytes
// the copy moves one byte per cycle through the single write port of the byte store
// the result turns valid as the input reopens; a result held by out_stall parks the next
// command in the result state and keeps in_stall high
// synchronous active-low reset clears fill count, capacity to 65536, no memory clearing;
// cfg_ready is always high, writes are expected only while idle

module lz77_match_copy_engine
  import lzmc_pkg::*;
#(
  parameter int BUFFER_BYTES = 65536,
  parameter int MAX_DISTANCE = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  // command input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_literal,
  input  logic [15:0] in_distance,
  input  logic [8:0]  in_match_length,
  input  logic [15:0] in_repeat_count,
  input  logic [15:0] in_read_position,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [16:0] out_fill_level,
  output logic [7:0]  out_read_byte,
  // capacity register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_capacity
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // capacity write is a direct register load
  assign cfg_ready = 1'b1;

  // sequencer: decode, match check, copy loop, result hand-off
  lzmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // byte store, fill count, limit checks, copy pointers, result register
  lzmc_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_DISTANCE (MAX_DISTANCE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid),
    .cfg_capacity     (cfg_capacity),
    .in_command       (in_command),
    .in_literal       (in_literal),
    .in_distance      (in_distance),
    .in_match_length  (in_match_length),
    .in_repeat_count  (in_repeat_count),
    .in_read_position (in_read_position),
    .out_status       (out_status),
    .out_fill_level   (out_fill_level),
    .out_read_byte    (out_read_byte)
  );

endmodule

/* rtl/core/lzmc_checker.sv */
module lzmc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic [16:0] out_fill_level,
  input logic [7:0]  out_read_byte
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_fill_level) && $stable(out_read_byte))
    else $error("result changed while stalled");

  // rejected commands never carry a byte
  a_rej_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_byte == 8'd0)
    else $error("rejected result with nonzero read byte");

  // one command in flight: a transfer closes the input
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lz77_match_copy_engine lzmc_checker u_lzmc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_fill_level (out_fill_level),
  .out_read_byte  (out_read_byte)
);

/* bench/lz77_match_copy_checker.sv */
`timescale 1ns / 1ps

module lz77_match_copy_checker
  import lzmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_literal,
  input  logic [15:0] in_distance,
  input  logic [8:0]  in_match_length,
  input  logic [15:0] in_repeat_count,
  input  logic [15:0] in_read_position,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_status,
  input  logic [16:0] out_fill_level,
  input  logic [7:0]  out_read_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] cfg_capacity,
  output int          fail_count,
  output int          pending,
  output logic [16:0] fill_now
);

  localparam int BUFFER_BYTES = 65536;
  localparam int WINDOW       = 32768;

  typedef struct packed {
    logic        status;
    logic [16:0] fill_level;
    logic [7:0]  read_byte;
  } copy_result_t;

  logic [7:0]   history [BUFFER_BYTES];
  int           held;
  int           cap_reg;
  int           errors = 0;
  copy_result_t result_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    fill_now   = '0;
  end

  function automatic copy_result_t apply_command(input logic [1:0] cmd, input logic [7:0] lit,
                                                 input int back, input int len, input int reps,
                                                 input int rpos);
    copy_result_t res;
    int limit;
    int total;
    res        = '0;
    res.status = 1'b1;
    limit      = (cap_reg < BUFFER_BYTES) ? cap_reg : BUFFER_BYTES;
    case (cmd)
      CMD_LITERAL: begin
        if (held < limit) begin
          history[held] = lit;
          held++;
          res.status = 1'b0;
        end
      end
      CMD_MATCH: begin
        total = reps * len;
        if (back != 0 && back <= held && back <= WINDOW && len >= int'(MIN_MATCH) &&
            len <= int'(MAX_MATCH) && held + total <= limit) begin
          // byte by byte so an overlapping source repeats its period
          for (int p = held; p < held + total; p++) history[p] = history[p - back];
          held += total;
          res.status = 1'b0;
        end
      end
      CMD_READ: begin
        if (rpos < held) begin
          res.read_byte = history[rpos];
          res.status    = 1'b0;
        end
      end
      default: ;
    endcase
    res.fill_level = held[16:0];
    return res;
  endfunction

  always @(posedge clk) begin
    copy_result_t want;
    if (!rst_n) begin
      held    = 0;
      cap_reg = int'(CAPACITY_RESET);
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = int'(cfg_capacity);
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          errors++;
          $error("result transfer with nothing outstanding");
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, out_status);
          end
          if (out_fill_level !== want.fill_level) begin
            errors++;
            $error("fill_level: expected %0d, got %0d", want.fill_level, out_fill_level);
          end
          if (out_read_byte !== want.read_byte) begin
            errors++;
            $error("read_byte: expected %0d, got %0d", want.read_byte, out_read_byte);
          end
        end
      end
      if (in_valid && !in_stall)
        result_q.push_back(apply_command(in_command, in_literal, int'(in_distance),
                                         int'(in_match_length), int'(in_repeat_count),
                                         int'(in_read_position)));
    end
    pending    <= result_q.size();
    fill_now   <= held[16:0];
    fail_count <= errors;
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lzmc_pkg::*;

  // command 3 has no meaning in the engine and must come back rejected
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         WINDOW     = 32768;
  localparam int         FULL_BUF   = 65536;
  // cycles with no transfer on any channel before the run is declared hung
  localparam int         HANG_LIMIT = 200000;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command       = '0;
  logic [7:0]  in_literal       = '0;
  logic [15:0] in_distance      = '0;
  logic [8:0]  in_match_length  = '0;
  logic [15:0] in_repeat_count  = '0;
  logic [15:0] in_read_position = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic        out_status;
  logic [16:0] out_fill_level;
  logic [7:0]  out_read_byte;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_capacity     = '0;

  // from the checker
  int          fails;
  int          pending;
  logic [16:0] fill_now;

  // shared between the sender and the receiver
  int          idle_max   = 6;
  bit          hold_req   = 1'b0;
  int          cap_now    = FULL_BUF;
  int          n_items    = 0;
  int          n_matches  = 0;
  int          n_reads    = 0;
  int          n_settings = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  lz77_match_copy_engine u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_literal       (in_literal),
    .in_distance      (in_distance),
    .in_match_length  (in_match_length),
    .in_repeat_count  (in_repeat_count),
    .in_read_position (in_read_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_fill_level   (out_fill_level),
    .out_read_byte    (out_read_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_capacity     (cfg_capacity)
  );

  lz77_match_copy_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_literal       (in_literal),
    .in_distance      (in_distance),
    .in_match_length  (in_match_length),
    .in_repeat_count  (in_repeat_count),
    .in_read_position (in_read_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_fill_level   (out_fill_level),
    .out_read_byte    (out_read_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_capacity     (cfg_capacity),
    .fail_count       (fails),
    .pending          (pending),
    .fill_now         (fill_now)
  );

  // one command transfer; valid stays up when the drawn gap is zero so
  // back-to-back transfers happen, and the payload is held while stalled
  task automatic send(input logic [1:0] cmd, input int lit, input int back,
                      input int len, input int reps, input int pos);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_literal       <= 8'(lit);
    in_distance      <= 16'(back);
    in_match_length  <= 9'(len);
    in_repeat_count  <= 16'(reps);
    in_read_position <= 16'(pos);
    do @(posedge clk); while (in_stall);
    n_items++;
    if (cmd == CMD_MATCH) n_matches++;
    if (cmd == CMD_READ) n_reads++;
  endtask

  // unused fields always carry random junk
  task automatic put_literal(input int b);
    send(CMD_LITERAL, b, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic put_match(input int back, input int len, input int reps);
    send(CMD_MATCH, $urandom, back, len, reps, $urandom);
  endtask

  task automatic put_read(input int pos);
    send(CMD_READ, $urandom, $urandom, $urandom, $urandom, pos);
  endtask

  // mostly well-formed commands steered by the predicted fill level, which
  // may lag one transfer behind; that only makes distances conservative
  task automatic send_random();
    int r;
    int k;
    int fill;
    int limit;
    int room;
    int far;
    int d;
    int l;
    int rp;
    fill  = int'(fill_now);
    limit = (cap_now < FULL_BUF) ? cap_now : FULL_BUF;
    room  = limit - fill;
    r     = $urandom_range(0, 99);
    if (r < 30 || (r < 65 && fill == 0)) begin
      put_literal($urandom_range(0, 255));
    end else if (r < 65) begin
      far = (fill < WINDOW) ? fill : WINDOW;
      case ($urandom_range(0, 3))
        0:       d = $urandom_range(1, (far < 8) ? far : 8);   // short period, heavy overlap
        1:       d = far;
        default: d = $urandom_range(1, far);
      endcase
      k = $urandom_range(0, 9);
      l = (k == 0) ? 3 : (k == 1) ? 258 : $urandom_range(3, 40);
      k = $urandom_range(0, 19);
      rp = (k == 0) ? 0 : (k == 1) ? $urandom_range(1, 64) : $urandom_range(1, 3);
      // usually trim to fit, sometimes let it bounce off the capacity
      if (rp * l > room && room >= l && $urandom_range(0, 3) != 0)
        rp = $urandom_range(1, room / l);
      put_match(d, l, rp);
    end else if (r < 90) begin
      k = $urandom_range(0, 9);
      if (fill == 0 || k == 9) put_read($urandom);
      else if (k < 6)          put_read($urandom_range(0, fill - 1));
      else                     put_read(fill + k - 7);   // around the fill edge
    end else begin
      case ($urandom_range(0, 4))
        0: send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: send(CMD_MATCH, $urandom, $urandom, $urandom, $urandom, $urandom);
        2: put_match(0, $urandom_range(3, 258), $urandom_range(0, 4));
        3: put_match($urandom_range(1, 4),
                     $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(259, 511),
                     $urandom_range(0, 4));
        default: put_match((fill >= 65535) ? 65535 : $urandom_range(fill + 1, 65535),
                           $urandom_range(3, 258), $urandom_range(0, 4));
      endcase
    end
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_capacity(input int value);
    cfg_valid    <= 1'b1;
    cfg_capacity <= 17'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_now = value;
    n_settings++;
  endtask

  // result side: random hold per transfer, or one long hold on request so
  // the engine backs up and stalls its input
  initial begin
    int hold;
    forever begin
      if (hold_req) begin
        hold     = 300;
        hold_req = 1'b0;
      end else begin
        hold = $urandom_range(0, idle_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // hang detector: any transfer on any channel restarts the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int fill;
    int room;
    int reps;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero capacity: nothing may be written, reads find nothing
    set_capacity(0);
    repeat (10) send_random();
    wait_idle();

    // small buffer, directed walk through the corner cases
    set_capacity(300);
    put_read(0);                   // unfilled read on empty buffer
    put_match(1, 3, 1);            // distance beyond fill
    send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
    put_literal(8'h00);
    put_literal(8'hff);
    put_literal(8'ha5);
    put_literal(8'h5a);
    put_match(0, 3, 1);            // zero distance
    put_match(5, 3, 1);            // one past the fill
    put_match(1, 2, 1);            // too short
    put_match(1, 259, 1);          // too long
    put_match(1, 511, 1);
    put_match(16'hffff, 3, 1);     // past fill and window
    put_match(1, 3, 0);            // zero repeats, no change
    put_match(1, 3, 2);            // overlap, period one
    put_match(3, 4, 3);            // periodic copy longer than its distance
    put_match(4, 258, 1);          // longest match
    put_match(2, 3, 16'hffff);     // blows the capacity
    put_match(10, 10, 2);          // lands exactly on capacity
    put_literal(8'h77);            // buffer full
    put_match(1, 3, 0);            // zero repeats still fit when full
    put_match(1, 3, 1);
    put_read(299);
    put_read(300);
    put_read(16'hffff);
    repeat (40) send_random();
    wait_idle();

    // capacity below the fill level
    set_capacity(200);
    repeat (40) send_random();
    wait_idle();

    // full size buffer, long random mix with two long output holds and
    // stretches where neither side idles
    set_capacity(FULL_BUF);
    hold_req = 1'b1;
    for (int i = 0; i < 1000; i++) begin
      idle_max = ((i / 100) % 3 == 2) ? 0 : 6;
      if (i == 500) hold_req = 1'b1;
      send_random();
    end
    idle_max = 6;
    wait_idle();

    // top off to the very last byte and probe the window edge
    fill = int'(fill_now);
    put_match(WINDOW, 3, 0);
    put_match(WINDOW + 1, 3, 0);
    put_read(16'h8000);
    room = FULL_BUF - fill;
    reps = room / 3;
    if (reps > 0) put_match(7, 3, reps);
    repeat (room - 3 * reps) put_literal($urandom_range(0, 255));
    put_literal(8'h3c);            // full
    put_match(1, 3, 0);
    put_read(16'hffff);
    put_read(0);
    wait_idle();

    // shrink again after filling
    set_capacity(100);
    repeat (20) send_random();
    wait_idle();
    repeat (10) @(posedge clk);

    $display("ran %0d commands (%0d match copies, %0d reads) over %0d capacity settings",
             n_items, n_matches, n_reads, n_settings);
    $display("buffer finished holding %0d bytes", fill_now);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
